// File: design/assert_macros.svh
// Assertion macros shared by the SGR parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SGRP_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SGRP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sgrp_pkg.sv
// Package: shared types, codes and the SGR code decoder for the parser.
`timescale 1ns / 1ps

package sgrp_pkg;

	localparam int MAX_SEQ_DEF = 32;

	// Byte values of the escape syntax
	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_M       = 8'h6D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// SGR parameter codes
	localparam logic [7:0] SGR_RESET      = 8'd0;
	localparam logic [7:0] SGR_BOLD_ON    = 8'd1;
	localparam logic [7:0] SGR_ITALIC_ON  = 8'd3;
	localparam logic [7:0] SGR_UL_ON      = 8'd4;
	localparam logic [7:0] SGR_BOLD_OFF   = 8'd22;
	localparam logic [7:0] SGR_ITALIC_OFF = 8'd23;
	localparam logic [7:0] SGR_UL_OFF     = 8'd24;
	localparam logic [7:0] SGR_FG_BLACK   = 8'd30;
	localparam logic [7:0] SGR_FG_RED     = 8'd31;
	localparam logic [7:0] SGR_FG_GREEN   = 8'd32;
	localparam logic [7:0] SGR_FG_YELLOW  = 8'd33;
	localparam logic [7:0] SGR_FG_BLUE    = 8'd34;
	localparam logic [7:0] SGR_FG_MAGENTA = 8'd35;
	localparam logic [7:0] SGR_FG_CYAN    = 8'd36;
	localparam logic [7:0] SGR_FG_WHITE   = 8'd37;
	localparam logic [7:0] SGR_FG_DEFAULT = 8'd39;
	localparam logic [7:0] SGR_FG_BRIGHT  = 8'd90;

	// Color index values
	localparam logic [3:0] COL_BLACK     = 4'd1;
	localparam logic [3:0] COL_GRAY80    = 4'd2;
	localparam logic [3:0] COL_GRAY50    = 4'd3;
	localparam logic [3:0] COL_DARKRED   = 4'd4;
	localparam logic [3:0] COL_DARKGREEN = 4'd5;
	localparam logic [3:0] COL_BROWN     = 4'd6;
	localparam logic [3:0] COL_BLUE      = 4'd7;
	localparam logic [3:0] COL_MAGENTA   = 4'd8;
	localparam logic [3:0] COL_LIGHTBLUE = 4'd9;

	typedef enum logic [2:0] {
		P_IDLE,
		P_ESC,
		P_BRACKET,
		P_DIGITS,
		P_SEMI
	} parse_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RD,
		SQ_OUT,
		SQ_BYTE
	} seq_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic accept;
		logic store;
		logic start_seq;
		logic param_set;
		logic param_acc;
		logic param_clr;
		logic apply;
		logic shadow_base;
		logic commit;
		logic clear;
		logic flush_start;
		logic rd_en;
		logic ridx_inc;
		logic load_byte;
		logic load_flush;
		logic last;
	} sgrp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic is_esc;
		logic is_bracket;
		logic is_digit;
		logic is_semi;
		logic is_m;
		logic sot;
		logic eot;
		logic full;
		logic cnt_nz;
		logic out_free;
		logic flush_last;
	} sgrp_stat_t;

	// style: [2:0] bold/italic/underline, [6:3] color index
	function automatic logic [6:0] apply_code(logic [6:0] s, logic [7:0] code,
			logic [2:0] base);
		logic [6:0] r;
		r = s;
		case (code)
			SGR_RESET:      r = {4'd0, base};
			SGR_BOLD_ON:    r = s | 7'b0000001;
			SGR_BOLD_OFF:   r = s & 7'b1111110;
			SGR_ITALIC_ON:  r = s | 7'b0000010;
			SGR_ITALIC_OFF: r = s & 7'b1111101;
			SGR_UL_ON:      r = s | 7'b0000100;
			SGR_UL_OFF:     r = s & 7'b1111011;
			SGR_FG_BLACK,
			SGR_FG_DEFAULT: r = {COL_BLACK, s[2:0]};
			SGR_FG_WHITE:   r = {COL_GRAY80, s[2:0]};
			SGR_FG_BRIGHT:  r = {COL_GRAY50, s[2:0]};
			SGR_FG_RED:     r = {COL_DARKRED, s[2:0]};
			SGR_FG_GREEN:   r = {COL_DARKGREEN, s[2:0]};
			SGR_FG_YELLOW:  r = {COL_BROWN, s[2:0]};
			SGR_FG_BLUE:    r = {COL_BLUE, s[2:0]};
			SGR_FG_MAGENTA: r = {COL_MAGENTA, s[2:0]};
			SGR_FG_CYAN:    r = {COL_LIGHTBLUE, s[2:0]};
			default:        r = s;
		endcase
		return r;
	endfunction

endpackage

// File: design/sgrp_dp.sv
// Datapath: pending byte buffer, parameter and style registers, output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgrp_dp #(
	parameter int MAX_SEQ = sgrp_pkg::MAX_SEQ_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          s_axis_tdata,
	input  logic                s_axis_tuser,
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [15:0]         m_axis_tdata,
	output logic                m_axis_tlast,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  sgrp_pkg::sgrp_cmd_t cmd,
	output sgrp_pkg::sgrp_stat_t st
);
	import sgrp_pkg::*;

	localparam int CNT_W = $clog2(MAX_SEQ + 1);
	localparam int IDX_W = $clog2(MAX_SEQ);

	logic [7:0]       mem [MAX_SEQ];
	logic [7:0]       rdata_q;
	logic [CNT_W-1:0] pcount_q;
	logic [CNT_W-1:0] flen_q;
	logic [IDX_W-1:0] ridx_q;
	logic [7:0]       param_q;
	logic [6:0]       committed_q;
	logic [6:0]       shadow_q;
	logic             seen_q;
	logic [2:0]       default_q;
	logic [7:0]       byte_q;
	logic             out_valid_q;
	logic [15:0]      out_data_q;
	logic             out_last_q;

	logic [7:0]       in_b;
	logic [3:0]       digit;
	logic [CNT_W-1:0] pcount_eff;
	logic [6:0]       base;
	logic [6:0]       committed_eff;
	logic             seen_eff;
	logic [6:0]       shadow_nx;
	logic [11:0]      acc;
	logic [IDX_W-1:0] waddr;

	assign in_b          = s_axis_tdata;
	assign digit         = 4'(in_b - CH_ZERO);
	assign base          = {4'd0, default_q};
	// start of text clears the pending sequence and style before the byte
	assign pcount_eff    = s_axis_tuser ? '0 : pcount_q;
	assign committed_eff = s_axis_tuser ? base : committed_q;
	assign seen_eff      = s_axis_tuser ? 1'b0 : seen_q;
	assign acc           = 12'(param_q) * 12'd10 + 12'(digit);
	assign waddr         = cmd.store ? pcount_eff[IDX_W-1:0] : '0;

	always_comb begin
		if (cmd.shadow_base) begin
			shadow_nx = base;
		end else if (cmd.apply) begin
			shadow_nx = apply_code(shadow_q, param_q, default_q);
		end else begin
			shadow_nx = shadow_q;
		end
	end

	always_comb begin
		st.is_esc     = (in_b == CH_ESC);
		st.is_bracket = (in_b == CH_BRACKET);
		st.is_digit   = (in_b >= CH_ZERO) && (in_b <= CH_NINE);
		st.is_semi    = (in_b == CH_SEMI);
		st.is_m       = (in_b == CH_M);
		st.sot        = s_axis_tuser;
		st.eot        = s_axis_tlast;
		st.full       = (pcount_eff == CNT_W'(MAX_SEQ));
		st.cnt_nz     = (pcount_eff != '0);
		st.out_free   = !out_valid_q || m_axis_tready;
		st.flush_last = (CNT_W'(ridx_q) + CNT_W'(1)) == flen_q;
	end

	// pending byte buffer
	always_ff @(posedge clk) begin
		if (cmd.accept && (cmd.store || cmd.start_seq)) begin
			mem[waddr] <= in_b;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[ridx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q   <= '0;
			pcount_q    <= '0;
			param_q     <= '0;
			committed_q <= '0;
			shadow_q    <= '0;
			seen_q      <= 1'b0;
			flen_q      <= '0;
			ridx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				default_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				pcount_q <= pcount_eff;
				if (cmd.clear) begin
					pcount_q <= '0;
				end else if (cmd.start_seq) begin
					pcount_q <= CNT_W'(1);
				end else if (cmd.store) begin
					pcount_q <= pcount_eff + CNT_W'(1);
				end

				if (cmd.clear || cmd.start_seq || cmd.param_clr) begin
					param_q <= '0;
				end else if (cmd.param_set) begin
					param_q <= 8'(digit);
				end else if (cmd.param_acc) begin
					param_q <= (acc > 12'd255) ? 8'd255 : acc[7:0];
				end

				if (s_axis_tuser) begin
					committed_q <= base;
					shadow_q    <= base;
					seen_q      <= 1'b0;
				end
				if (cmd.start_seq) begin
					shadow_q <= committed_eff;
				end else if (cmd.shadow_base || cmd.apply) begin
					shadow_q <= shadow_nx;
				end
				if (cmd.commit) begin
					committed_q <= shadow_nx;
					seen_q      <= 1'b1;
				end
			end
			if (cmd.flush_start) begin
				flen_q <= pcount_eff;
				ridx_q <= '0;
			end else if (cmd.ridx_inc) begin
				ridx_q <= ridx_q + IDX_W'(1);
			end
			if (cmd.load_byte || cmd.load_flush) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload; style is fixed for all items of one input
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_b;
		end
		if (cmd.load_byte || cmd.load_flush) begin
			out_last_q <= cmd.last;
			if (cmd.accept) begin
				out_data_q <= {seen_eff, committed_eff, in_b};
			end else if (cmd.load_flush) begin
				out_data_q <= {seen_q, committed_q, rdata_q};
			end else begin
				out_data_q <= {seen_q, committed_q, byte_q};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	`SGRP_ASSERT(a_cnt_range, clk, arst_n, pcount_q <= CNT_W'(MAX_SEQ), "pending count overflow")
	`SGRP_ASSERT_NEXT(a_commit_clr, clk, arst_n, cmd.accept && cmd.commit, pcount_q == '0 && param_q == '0, "commit left sequence state")

endmodule

// File: design/sgrp_ctrl.sv
// Controller: escape sequence parser state and flush sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgrp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  sgrp_pkg::sgrp_stat_t st,
	output sgrp_pkg::sgrp_cmd_t  cmd
);
	import sgrp_pkg::*;

	parse_state_t parse_q, parse_d, ps_e, nps;
	seq_state_t   sq_q, sq_d;
	logic         epend_q, epend_d;
	logic         flush, emit, brk, dump, overflow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= P_IDLE;
			sq_q    <= SQ_IDLE;
			epend_q <= 1'b0;
		end else begin
			parse_q <= parse_d;
			sq_q    <= sq_d;
			epend_q <= epend_d;
		end
	end

	always_comb begin
		cmd           = '0;
		s_axis_tready = 1'b0;
		parse_d       = parse_q;
		sq_d          = sq_q;
		epend_d       = epend_q;
		ps_e          = st.sot ? P_IDLE : parse_q;
		nps           = ps_e;
		flush         = 1'b0;
		emit          = 1'b0;
		brk           = 1'b0;
		dump          = 1'b0;
		overflow      = 1'b0;
		case (sq_q)
			SQ_IDLE: begin
				s_axis_tready = st.out_free;
				if (s_axis_tvalid && st.out_free) begin
					cmd.accept = 1'b1;
					case (ps_e)
						P_IDLE: begin
							if (st.is_esc) begin
								cmd.start_seq = 1'b1;
								nps = P_ESC;
							end else begin
								emit = 1'b1;
							end
						end
						P_ESC: begin
							if (st.is_bracket) begin
								if (st.full) begin
									overflow = 1'b1;
								end else begin
									cmd.store = 1'b1;
									nps = P_BRACKET;
								end
							end else begin
								brk = 1'b1;
							end
						end
						P_BRACKET, P_SEMI: begin
							if (st.is_digit) begin
								if (st.full) begin
									overflow = 1'b1;
								end else begin
									cmd.store     = 1'b1;
									cmd.param_set = 1'b1;
									nps = P_DIGITS;
								end
							end else if (st.is_m && ps_e == P_BRACKET) begin
								// empty parameter list acts as a reset
								cmd.shadow_base = 1'b1;
								cmd.commit      = 1'b1;
								nps = P_IDLE;
							end else begin
								brk = 1'b1;
							end
						end
						P_DIGITS: begin
							if (st.is_digit) begin
								if (st.full) begin
									overflow = 1'b1;
								end else begin
									cmd.store     = 1'b1;
									cmd.param_acc = 1'b1;
								end
							end else if (st.is_semi) begin
								if (st.full) begin
									overflow = 1'b1;
								end else begin
									cmd.store     = 1'b1;
									cmd.apply     = 1'b1;
									cmd.param_clr = 1'b1;
									nps = P_SEMI;
								end
							end else if (st.is_m) begin
								cmd.apply  = 1'b1;
								cmd.commit = 1'b1;
								nps = P_IDLE;
							end else begin
								brk = 1'b1;
							end
						end
						default: begin
							nps = P_IDLE;
						end
					endcase

					if (brk) begin
						flush = 1'b1;
						if (st.is_esc) begin
							cmd.start_seq = 1'b1;
							nps = P_ESC;
						end else begin
							emit = 1'b1;
							nps = P_IDLE;
						end
					end
					// overflow, or end of text on an open sequence: pending bytes, then this byte
					dump = overflow || (st.eot && nps != P_IDLE);
					if (dump) begin
						flush          = 1'b1;
						emit           = 1'b1;
						cmd.store      = 1'b0;
						cmd.start_seq  = 1'b0;
						nps = P_IDLE;
					end
					cmd.clear = (nps == P_IDLE);
					parse_d   = nps;

					if (flush && st.cnt_nz) begin
						cmd.flush_start = 1'b1;
						epend_d = emit;
						sq_d    = SQ_RD;
					end else if (emit) begin
						cmd.load_byte = 1'b1;
						cmd.last      = 1'b1;
					end
				end
			end
			SQ_RD: begin
				cmd.rd_en = 1'b1;
				sq_d      = SQ_OUT;
			end
			SQ_OUT: begin
				if (st.out_free) begin
					cmd.load_flush = 1'b1;
					cmd.last       = st.flush_last && !epend_q;
					if (st.flush_last) begin
						sq_d = epend_q ? SQ_BYTE : SQ_IDLE;
					end else begin
						cmd.ridx_inc = 1'b1;
						sq_d = SQ_RD;
					end
				end
			end
			SQ_BYTE: begin
				if (st.out_free) begin
					cmd.load_byte = 1'b1;
					cmd.last      = 1'b1;
					epend_d       = 1'b0;
					sq_d          = SQ_IDLE;
				end
			end
			default: begin
				sq_d = SQ_IDLE;
			end
		endcase
	end

	// a flush follows a break, an overflow or end of text, so the parser sits idle or on a fresh ESC
	`SGRP_ASSERT(a_flush_parse, clk, arst_n, sq_q == SQ_IDLE || parse_q == P_IDLE || parse_q == P_ESC, "parser advanced during flush")
	`SGRP_ASSERT(a_byte_pend, clk, arst_n, sq_q != SQ_BYTE || epend_q, "trailing byte state without pending byte")

endmodule

// File: design/sgr_escape_style_parser.sv
// Top level: SGR escape sequence parser with style tracking.
`timescale 1ns / 1ps

// Strips ESC [ n;n;... m sequences from a byte stream and tags every other byte
// with its style (bold, italic, underline, color index). Plain text moves one
// item per cycle unless the output stalls. A sequence that breaks off, overflows
// the MAX_SEQ-byte pending buffer or is cut by end of text is replayed as text:
// each buffered byte is read from the single-port buffer into a data register
// and then output, then the flush-causing byte unless it opens a sequence; no
// input is taken during that replay. A completed sequence emits nothing and
// applies its codes in order on the final m. Input tuser = start of text, input
// tlast = end of text; output tlast marks the last item caused by one input item.
module sgr_escape_style_parser #(
	parameter int MAX_SEQ = sgrp_pkg::MAX_SEQ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // start_of_text
	input  logic        s_axis_tlast,  // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte, [8] is_bold, [9] is_italic, [10] is_underlined,
	// [14:11] color_index, [15] formatting_seen
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast,  // last_of_run
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata      // default_style
);
	import sgrp_pkg::*;

	sgrp_cmd_t  cmd;
	sgrp_stat_t st;

	sgrp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.st            (st),
		.cmd           (cmd)
	);

	sgrp_dp #(
		.MAX_SEQ (MAX_SEQ)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.st            (st)
	);

endmodule

// File: verif/sgr_style_checker.sv
// Checker for the SGR parser: predicts the styled output stream and compares every result item.
`timescale 1ns / 1ps
module sgr_style_checker #(
	parameter int MAX_SEQ = sgrp_pkg::MAX_SEQ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // start_of_text
	input  logic        s_axis_tlast,   // end_of_text
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte, [8] is_bold, [9] is_italic, [10] is_underlined,
	// [14:11] color_index, [15] formatting_seen
	input  logic [15:0] m_axis_tdata,
	input  logic        m_axis_tlast,   // last_of_run
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,      // default_style
	output int          mismatches,
	output int          owed
);
	import sgrp_pkg::*;

	typedef struct packed {
		logic [3:0] color;
		logic       underline;
		logic       italic;
		logic       bold;
	} style_t;

	typedef struct {
		logic [7:0] text;
		style_t     style;
		logic       seen;
		logic       last;
	} styled_byte_t;

	logic [2:0]   font_default;
	parse_state_t pstate;
	logic [7:0]   seq_buf [MAX_SEQ];
	int           seq_len;
	int           param;
	style_t       cur_style;
	style_t       next_style;
	logic         seen;
	int           step_n;
	styled_byte_t styled_q [$];

	function automatic style_t default_look();
		return style_t'({4'd0, font_default});
	endfunction

	function automatic style_t apply_sgr(style_t s, int code);
		style_t r;
		r = s;
		case (8'(code))
			SGR_RESET:      r = default_look();
			SGR_BOLD_ON:    r.bold = 1'b1;
			SGR_BOLD_OFF:   r.bold = 1'b0;
			SGR_ITALIC_ON:  r.italic = 1'b1;
			SGR_ITALIC_OFF: r.italic = 1'b0;
			SGR_UL_ON:      r.underline = 1'b1;
			SGR_UL_OFF:     r.underline = 1'b0;
			SGR_FG_BLACK,
			SGR_FG_DEFAULT: r.color = COL_BLACK;
			SGR_FG_WHITE:   r.color = COL_GRAY80;
			SGR_FG_BRIGHT:  r.color = COL_GRAY50;
			SGR_FG_RED:     r.color = COL_DARKRED;
			SGR_FG_GREEN:   r.color = COL_DARKGREEN;
			SGR_FG_YELLOW:  r.color = COL_BROWN;
			SGR_FG_BLUE:    r.color = COL_BLUE;
			SGR_FG_MAGENTA: r.color = COL_MAGENTA;
			SGR_FG_CYAN:    r.color = COL_LIGHTBLUE;
			default:        r = s;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	task automatic emit_text(logic [7:0] b);
		styled_byte_t e;
		e.text = b;
		e.style = cur_style;
		e.seen = seen;
		e.last = 1'b0;
		styled_q.push_back(e);
		step_n++;
	endtask

	// pending bytes go out as plain text in the committed style
	task automatic replay_seq();
		for (int i = 0; i < seq_len; i++)
			emit_text(seq_buf[i]);
		seq_len = 0;
		param = 0;
		pstate = P_IDLE;
	endtask

	task automatic grow_seq(input logic [7:0] b, output bit stored);
		if (seq_len >= MAX_SEQ) begin
			replay_seq();
			emit_text(b);
			stored = 1'b0;
		end else begin
			seq_buf[seq_len] = b;
			seq_len++;
			stored = 1'b1;
		end
	endtask

	task automatic take_style();
		cur_style = next_style;
		seen = 1'b1;
		seq_len = 0;
		param = 0;
		pstate = P_IDLE;
	endtask

	task automatic begin_or_pass(logic [7:0] b);
		if (b == CH_ESC) begin
			seq_buf[0] = b;
			seq_len = 1;
			param = 0;
			next_style = cur_style;
			pstate = P_ESC;
		end else begin
			emit_text(b);
		end
	endtask

	task automatic track_byte(logic [7:0] b, logic sot, logic eot);
		bit is_digit;
		bit ok;
		styled_byte_t e;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		step_n = 0;
		if (sot) begin
			cur_style = default_look();
			next_style = default_look();
			seq_len = 0;
			param = 0;
			pstate = P_IDLE;
			seen = 1'b0;
		end
		case (pstate)
			P_ESC: begin
				if (b == CH_BRACKET) begin
					grow_seq(b, ok);
					if (ok)
						pstate = P_BRACKET;
				end else begin
					replay_seq();
					begin_or_pass(b);
				end
			end
			P_BRACKET, P_SEMI: begin
				if (is_digit) begin
					grow_seq(b, ok);
					if (ok) begin
						param = int'(b) - int'(CH_ZERO);
						pstate = P_DIGITS;
					end
				end else if (b == CH_M && pstate == P_BRACKET) begin
					// empty list behaves as a reset
					next_style = default_look();
					take_style();
				end else begin
					replay_seq();
					begin_or_pass(b);
				end
			end
			P_DIGITS: begin
				if (is_digit) begin
					grow_seq(b, ok);
					if (ok) begin
						param = param * 10 + int'(b) - int'(CH_ZERO);
						if (param > 255)
							param = 255;
					end
				end else if (b == CH_SEMI) begin
					grow_seq(b, ok);
					if (ok) begin
						next_style = apply_sgr(next_style, param);
						param = 0;
						pstate = P_SEMI;
					end
				end else if (b == CH_M) begin
					next_style = apply_sgr(next_style, param);
					take_style();
				end else begin
					replay_seq();
					begin_or_pass(b);
				end
			end
			default: begin
				pstate = P_IDLE;
				begin_or_pass(b);
			end
		endcase
		if (eot && pstate != P_IDLE)
			replay_seq();
		if (step_n > 0) begin
			e = styled_q.pop_back();
			e.last = 1'b1;
			styled_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		styled_byte_t want;
		if (!arst_n) begin
			font_default = 3'd0;
			pstate = P_IDLE;
			seq_len = 0;
			param = 0;
			cur_style = '0;
			next_style = '0;
			seen = 1'b0;
			styled_q.delete();
			owed <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				track_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (styled_q.size() == 0) begin
					report_mismatch($sformatf("item %0h with nothing outstanding",
						m_axis_tdata));
				end else begin
					want = styled_q.pop_front();
					check_field("out_byte", m_axis_tdata[7:0], want.text);
					check_field("is_bold", m_axis_tdata[8], want.style.bold);
					check_field("is_italic", m_axis_tdata[9], want.style.italic);
					check_field("is_underlined", m_axis_tdata[10], want.style.underline);
					check_field("color_index", m_axis_tdata[14:11], want.style.color);
					check_field("formatting_seen", m_axis_tdata[15], want.seen);
					check_field("last_of_run", m_axis_tlast, want.last);
				end
			end
			if (cfg_we)
				font_default = cfg_wdata;
			owed <= styled_q.size();
		end
	end

endmodule

// File: verif/tb_sgr_escape_style_parser.sv
// Testbench top: byte stimulus, style settings, output backpressure and the final verdict.
`timescale 1ns / 1ps
module tb_sgr_escape_style_parser;
	import sgrp_pkg::*;

	// covers a full replay of a filled pending buffer
	localparam int SETTLE_CYCLES = 2 * MAX_SEQ_DEF + 8;
	localparam int STALL_LIMIT   = 1000;
	localparam int PHASE_ITEMS   = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;   // start_of_text
	logic        s_axis_tlast = 1'b0;   // end_of_text
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] out_byte, [8] is_bold, [9] is_italic, [10] is_underlined,
	// [14:11] color_index, [15] formatting_seen
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;          // last_of_run
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = 3'd0;      // default_style

	int   mismatches;
	int   owed;
	int   stuck = 0;
	int   hold_left = 0;
	int   items_sent = 0;
	logic jitter = 1'b1;

	logic [7:0] known_codes [17] = '{SGR_RESET, SGR_BOLD_ON, SGR_ITALIC_ON, SGR_UL_ON,
		SGR_BOLD_OFF, SGR_ITALIC_OFF, SGR_UL_OFF, SGR_FG_BLACK, SGR_FG_RED, SGR_FG_GREEN,
		SGR_FG_YELLOW, SGR_FG_BLUE, SGR_FG_MAGENTA, SGR_FG_CYAN, SGR_FG_WHITE,
		SGR_FG_DEFAULT, SGR_FG_BRIGHT};

	sgr_escape_style_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	sgr_style_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.owed          (owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// random output backpressure in bursts
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (jitter && $urandom_range(0, 9) == 0) begin
			hold_left <= $urandom_range(1, 16) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we) begin
			stuck <= 0;
		end else if (stuck == STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic sot, input logic eot);
		if (jitter && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= sot;
		s_axis_tlast <= eot;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// owed is registered, so look only after the next edge
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
	endtask

	task automatic write_default(input logic [2:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] burst [$];
		logic [2:0] phase_default [4];
		int         code;
		int         pick;
		int         nparams;
		int         target;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_default(3'd0);

		// extremes of the byte, start of text
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		// empty parameter list
		send_item(CH_ESC, 1'b0, 1'b0);
		send_item(CH_BRACKET, 1'b0, 1'b0);
		send_item(CH_M, 1'b0, 1'b0);
		send_item("A", 1'b0, 1'b0);
		// bold, then a parameter that saturates and is ignored
		send_item(CH_ESC, 1'b0, 1'b0);
		send_item(CH_BRACKET, 1'b0, 1'b0);
		send_item("1", 1'b0, 1'b0);
		send_item(CH_SEMI, 1'b0, 1'b0);
		send_item("2", 1'b0, 1'b0);
		send_item("5", 1'b0, 1'b0);
		send_item("6", 1'b0, 1'b0);
		send_item(CH_M, 1'b0, 1'b0);
		send_item("B", 1'b0, 1'b0);
		// m right after a semicolon breaks the sequence
		send_item(CH_ESC, 1'b0, 1'b0);
		send_item(CH_BRACKET, 1'b0, 1'b0);
		send_item("3", 1'b0, 1'b0);
		send_item(CH_SEMI, 1'b0, 1'b0);
		send_item(CH_M, 1'b0, 1'b0);
		// ESC inside a sequence restarts it; code 0 resets
		send_item(CH_ESC, 1'b0, 1'b0);
		send_item(CH_ESC, 1'b0, 1'b0);
		send_item(CH_BRACKET, 1'b0, 1'b0);
		send_item("0", 1'b0, 1'b0);
		send_item(CH_M, 1'b0, 1'b0);
		// end of text cuts an open sequence
		send_item(CH_ESC, 1'b0, 1'b0);
		send_item(CH_BRACKET, 1'b0, 1'b0);
		send_item("4", 1'b0, 1'b1);

		phase_default[0] = 3'd7;
		phase_default[1] = 3'($urandom_range(1, 6));
		phase_default[2] = 3'd0;
		phase_default[3] = 3'($urandom_range(0, 7));

		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 3)
				jitter <= 1'b0;
			write_default(phase_default[phase]);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				burst.delete();
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					// well-formed below 45, broken off above
					burst.push_back(CH_ESC);
					burst.push_back(CH_BRACKET);
					nparams = $urandom_range(0, 4);
					for (int k = 0; k < nparams; k++) begin
						if (k > 0)
							burst.push_back(CH_SEMI);
						if ($urandom_range(0, 4) == 0)
							code = $urandom_range(0, 999);
						else
							code = known_codes[$urandom_range(0, 16)];
						if ($urandom_range(0, 7) == 0)
							burst.push_back(CH_ZERO);
						if (code >= 100)
							burst.push_back(8'(CH_ZERO + code / 100));
						if (code >= 10)
							burst.push_back(8'(CH_ZERO + code / 10 % 10));
						burst.push_back(8'(CH_ZERO + code % 10));
					end
					if (pick < 45) begin
						burst.push_back(CH_M);
					end else begin
						case ($urandom_range(0, 2))
							0: begin
								burst.push_back(CH_SEMI);
								burst.push_back(CH_M);
							end
							1: burst.push_back(CH_ESC);
							default: burst.push_back(8'($urandom_range(0, 255)));
						endcase
					end
				end else if (pick < 66) begin
					// comes near the buffer size, fills it exactly or runs past it
					burst.push_back(CH_ESC);
					burst.push_back(CH_BRACKET);
					repeat ($urandom_range(MAX_SEQ_DEF - 3, MAX_SEQ_DEF))
						burst.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
					burst.push_back(CH_M);
				end else if (pick < 90) begin
					repeat ($urandom_range(1, 6))
						burst.push_back(8'($urandom_range(32, 126)));
				end else begin
					repeat ($urandom_range(1, 4))
						burst.push_back(8'($urandom_range(0, 255)));
				end
				foreach (burst[i])
					send_item(burst[i], $urandom_range(0, 79) == 0, $urandom_range(0, 49) == 0);
				if ($urandom_range(0, 59) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/sgrp_pkg.sv
design/sgrp_dp.sv
design/sgrp_ctrl.sv
design/sgr_escape_style_parser.sv
verif/sgr_style_checker.sv
verif/tb_sgr_escape_style_parser.sv
